[hdl/aces_luminance_tone_map_defines.svh]
// Assertion macros shared by the tone mapper RTL.
`ifndef ACES_LUMINANCE_TONE_MAP_DEFINES_SVH
`define ACES_LUMINANCE_TONE_MAP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ALTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("altm: same-cycle check failed");
`define ALTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("altm: next-cycle check failed");
`else
`define ALTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ALTM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/altm_pkg.sv]
// Types and constants of the ACES luminance tone mapper.
`default_nettype none
package altm_pkg;

    // Rec.709 luma weights, Q0.16, summing to 65536
    localparam logic [15:0] WR = 16'd13933;
    localparam logic [15:0] WG = 16'd46871;
    localparam logic [15:0] WB = 16'd4732;

    // Curve constants in Q16, with the linear and constant terms prescaled
    localparam logic [17:0] CA      = 18'd164495;
    localparam logic [17:0] CC      = 18'd159252;
    localparam logic [33:0] CB_1024 = 34'd2013184;
    localparam logic [33:0] CD_1024 = 34'd39593984;
    localparam logic [49:0] CE_SH20 = 50'd9620684800;

    localparam logic [4:0]  LUMA_EPSILON = 5'd1;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [11:0] OUT_MAX      = 12'd4095;

    // Pipeline shape
    localparam int DIV_Y_STEPS    = 17;
    localparam int CURVE_PRE      = 4;
    localparam int CURVE_STAGES   = CURVE_PRE + DIV_Y_STEPS;
    localparam int LANE_PRE       = 3;
    localparam int LANE_DIV_STEPS = 12;
    localparam int LANE_STAGES    = LANE_PRE + LANE_DIV_STEPS;
    localparam int PIPE_STAGES    = CURVE_STAGES + LANE_STAGES + 1;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [11:0] red_out;
        logic [11:0] green_out;
        logic [11:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        t_pix_in     pix;
        logic [15:0] lum;
        logic [16:0] y;
    } t_curve;

endpackage
`default_nettype wire

[hdl/altm_curve.sv]
// Luminance and filmic curve: luma sum, rational terms and pipelined divider.
`default_nettype none
module altm_curve (
    input  wire logic                                i_clk,
    input  wire logic [altm_pkg::CURVE_STAGES-1:0]   i_en,
    input  wire altm_pkg::t_pix_in                   i_pix,
    output altm_pkg::t_curve                         o_curve
);

    localparam int NS = altm_pkg::DIV_Y_STEPS;
    localparam int PRE = altm_pkg::CURVE_PRE;

    logic [31:0]       n_sum;
    logic [15:0]       r_lum0, r_lum1, r_lum2, r_lum3;
    altm_pkg::t_pix_in r_pix0, r_pix1, r_pix2, r_pix3;
    logic [33:0]       r_aterm, r_cterm;
    logic [49:0]       r_num, r_den;
    logic [62:0]       r_dvd;
    logic [45:0]       r_d4;

    logic [62:0]       r_rem [NS];
    logic [45:0]       r_dvs [NS];
    logic [16:0]       r_quo [NS];
    altm_pkg::t_pix_in r_dpix [NS];
    logic [15:0]       r_dlum [NS];

    // Form luminance, rounded
    assign n_sum = 32'(altm_pkg::WR) * 32'(i_pix.red_in)
                 + 32'(altm_pkg::WG) * 32'(i_pix.green_in)
                 + 32'(altm_pkg::WB) * 32'(i_pix.blue_in) + 32'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lum0 <= n_sum[31:16];
            r_pix0 <= i_pix;
        end
    end

    // Inner terms of numerator and denominator
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_aterm <= 34'(altm_pkg::CA) * 34'(r_lum0) + altm_pkg::CB_1024;
            r_cterm <= 34'(altm_pkg::CC) * 34'(r_lum0) + altm_pkg::CD_1024;
            r_lum1  <= r_lum0;
            r_pix1  <= r_pix0;
        end
    end

    // Outer multiply
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_num  <= 50'(r_lum1) * 50'(r_aterm);
            r_den  <= 50'(r_lum1) * 50'(r_cterm) + altm_pkg::CE_SH20;
            r_lum2 <= r_lum1;
            r_pix2 <= r_pix1;
        end
    end

    // Dividend with rounding half, divisor truncated by four bits
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_dvd  <= {1'b0, r_num, 12'd0} + 63'(r_den[49:5]);
            r_d4   <= r_den[49:4];
            r_lum3 <= r_lum2;
            r_pix3 <= r_pix2;
        end
    end

    // Restoring divider, one quotient bit per stage, MSB first
    for (genvar j = 0; j < NS; j++) begin : g_ydiv
        logic [62:0]       w_rem_in;
        logic [45:0]       w_dvs_in;
        logic [16:0]       w_quo_in;
        altm_pkg::t_pix_in w_pix_in;
        logic [15:0]       w_lum_in;
        logic [62:0]       w_sub;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = r_dvd;
            assign w_dvs_in = r_d4;
            assign w_quo_in = 17'd0;
            assign w_pix_in = r_pix3;
            assign w_lum_in = r_lum3;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_dvs_in = r_dvs[j-1];
            assign w_quo_in = r_quo[j-1];
            assign w_pix_in = r_dpix[j-1];
            assign w_lum_in = r_dlum[j-1];
        end

        assign w_sub = 63'(w_dvs_in) << (NS - 1 - j);
        assign w_ge  = (w_rem_in >= w_sub);

        always_ff @(posedge i_clk) begin
            if (i_en[PRE + j]) begin
                r_rem[j]  <= w_ge ? (w_rem_in - w_sub) : w_rem_in;
                r_quo[j]  <= w_quo_in | (w_ge ? (17'd1 << (NS - 1 - j)) : 17'd0);
                r_dvs[j]  <= w_dvs_in;
                r_dpix[j] <= w_pix_in;
                r_dlum[j] <= w_lum_in;
            end
        end
    end

    assign o_curve.pix = r_dpix[NS-1];
    assign o_curve.lum = r_dlum[NS-1];
    assign o_curve.y   = r_quo[NS-1];

endmodule
`default_nettype wire

[hdl/altm_lane.sv]
// One channel lane: scale by curve gain and divide by luminance plus epsilon.
`default_nettype none
module altm_lane (
    input  wire logic                               i_clk,
    input  wire logic [altm_pkg::LANE_STAGES-1:0]   i_en,
    input  wire logic [15:0]                        i_ch,
    input  wire logic [15:0]                        i_lum,
    input  wire logic [16:0]                        i_y,
    output logic [11:0]                             o_val
);

    localparam int NS = altm_pkg::LANE_DIV_STEPS;
    localparam int PRE = altm_pkg::LANE_PRE;

    logic [16:0] n_ysat;
    logic [32:0] r_prod;
    logic [16:0] r_lp0, r_lp1, r_lp2;
    logic [44:0] n_p;
    logic [45:0] n_sum;
    logic [29:0] r_x, r_x2;
    logic        r_ovf;

    logic [29:0] r_rem [NS];
    logic [16:0] r_dvs [NS];
    logic [11:0] r_quo [NS];
    logic        r_sat [NS];

    // Clamp curve to 1.0 and apply to channel
    assign n_ysat = (i_y > altm_pkg::ONE_Q16) ? altm_pkg::ONE_Q16 : i_y;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= 33'(i_ch) * 33'(n_ysat);
            r_lp0  <= 17'(i_lum) + 17'(altm_pkg::LUMA_EPSILON);
        end
    end

    // Times 4095, add half divisor, drop the Q16 part of the product
    assign n_p   = (45'(r_prod) << 12) - 45'(r_prod);
    assign n_sum = 46'(n_p) + (46'(r_lp0) << 15);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x   <= n_sum[45:16];
            r_lp1 <= r_lp0;
        end
    end

    // Flag quotients of 4096 and above
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_ovf <= (r_x >= (30'(r_lp1) << 12));
            r_x2  <= r_x;
            r_lp2 <= r_lp1;
        end
    end

    // Twelve-bit restoring divider
    for (genvar j = 0; j < NS; j++) begin : g_cdiv
        logic [29:0] w_rem_in;
        logic [16:0] w_dvs_in;
        logic [11:0] w_quo_in;
        logic        w_sat_in;
        logic [29:0] w_sub;
        logic        w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = r_x2;
            assign w_dvs_in = r_lp2;
            assign w_quo_in = 12'd0;
            assign w_sat_in = r_ovf;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_dvs_in = r_dvs[j-1];
            assign w_quo_in = r_quo[j-1];
            assign w_sat_in = r_sat[j-1];
        end

        assign w_sub = 30'(w_dvs_in) << (NS - 1 - j);
        assign w_ge  = (w_rem_in >= w_sub);

        always_ff @(posedge i_clk) begin
            if (i_en[PRE + j]) begin
                r_rem[j] <= w_ge ? (w_rem_in - w_sub) : w_rem_in;
                r_quo[j] <= w_quo_in | (w_ge ? (12'd1 << (NS - 1 - j)) : 12'd0);
                r_dvs[j] <= w_dvs_in;
                r_sat[j] <= w_sat_in;
            end
        end
    end

    // Saturate
    assign o_val = r_sat[NS-1] ? altm_pkg::OUT_MAX : r_quo[NS-1];

endmodule
`default_nettype wire

[hdl/aces_luminance_tone_map.sv]
// Top level of the ACES luminance tone mapper: control, lanes and output word.
`default_nettype none
`include "aces_luminance_tone_map_defines.svh"
// Takes one HDR pixel word per clock and returns one tone-mapped word per clock
// while the output is not stalled. The pipeline is the pipelined 17-step curve
// divider (21 stages with the luma and curve multiplies) followed by three
// parallel channel lanes, each a 12-step pipelined divider (15 stages), and the
// output register. Every stage holds a valid bit; a stalled output lets earlier
// stages keep filling, so new words are taken while bubbles remain.
module aces_luminance_tone_map (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire altm_pkg::t_pix_in  i_pix,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output altm_pkg::t_pix_out      o_pix
);

    localparam int NP = altm_pkg::PIPE_STAGES;
    localparam int NC = altm_pkg::CURVE_STAGES;
    localparam int NL = altm_pkg::LANE_STAGES;

    logic [NP-1:0]      r_vld, n_vld, w_en;
    altm_pkg::t_curve   w_curve;
    logic [11:0]        w_red, w_green, w_blue;
    altm_pkg::t_pix_out r_out;

    // Advance a stage when it or any later stage is empty, or the output drains
    for (genvar k = 0; k < NP; k++) begin : g_en
        assign w_en[k] = i_out_ready || !(&r_vld[NP-1:k]);
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NP; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NP-1];

    // Luminance and curve gain
    altm_curve u_curve (
        .i_clk   (i_clk),
        .i_en    (w_en[NC-1:0]),
        .i_pix   (i_pix),
        .o_curve (w_curve)
    );

    // One lane per channel
    altm_lane u_lane_red (
        .i_clk (i_clk),
        .i_en  (w_en[NC+NL-1:NC]),
        .i_ch  (w_curve.pix.red_in),
        .i_lum (w_curve.lum),
        .i_y   (w_curve.y),
        .o_val (w_red)
    );

    altm_lane u_lane_green (
        .i_clk (i_clk),
        .i_en  (w_en[NC+NL-1:NC]),
        .i_ch  (w_curve.pix.green_in),
        .i_lum (w_curve.lum),
        .i_y   (w_curve.y),
        .o_val (w_green)
    );

    altm_lane u_lane_blue (
        .i_clk (i_clk),
        .i_en  (w_en[NC+NL-1:NC]),
        .i_ch  (w_curve.pix.blue_in),
        .i_lum (w_curve.lum),
        .i_y   (w_curve.y),
        .o_val (w_blue)
    );

    // Merge lane results into the output word
    always_ff @(posedge i_clk) begin
        if (w_en[NP-1]) begin
            r_out.red_out   <= w_red;
            r_out.green_out <= w_green;
            r_out.blue_out  <= w_blue;
        end
    end

    assign o_pix = r_out;

    `ALTM_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, (&r_vld) && !i_out_ready, !o_in_ready)
    `ALTM_ASSERT_NXT(a_accept_fill, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])
    `ALTM_ASSERT_NXT(a_drain_adv, i_clk, i_rst_n, r_vld[NP-2] && i_out_ready, o_out_valid)

endmodule
`default_nettype wire
